/* rtl/ddpu_pkg.sv */
// types and constants of the differential drive pose update block
`timescale 1ns / 1ps
`default_nettype none
package ddpu_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_ROT, S_VEC, S_FIN,
    S_ST0, S_ST1, S_ST2, S_ST3,
    S_DIV, S_R, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_OUT
  } state_t;

  // what a finished rotation run is used for
  typedef enum logic [1:0] {P_FIRST, P_TURN, P_FINAL} phase_t;

  localparam logic [1:0] REG_START_X   = 2'd0;
  localparam logic [1:0] REG_START_Y   = 2'd1;
  localparam logic [1:0] REG_START_HDG = 2'd2;

  localparam logic signed [33:0] KGAIN_Q30     = 34'sd652032874;
  localparam logic signed [34:0] RAD_TO_TURN32 = 35'sd2670177;
  localparam int DIV_BITS = 33;
  localparam int TAB_LEN  = 24;

  // atan(2^-i) in 2^32 per turn
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -72'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = (35'(v) + 35'sd32768) >>> 16;
    if (r > 35'sd16384) return 16'sd16384;
    else if (r < -35'sd16384) return 16'hC000;
    else return r[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/diff_drive_pose_update_top.sv */
// Differential drive pose tracker: dead reckoning with rotation about the
// instantaneous centre of curvature, one shared cordic, divider and multiplier.
// A curved step uses three rotation runs, a 33-step radius divide and a series
// of multiplies; an item waits in its last state while the output register is
// full. The cordic is a single stage and the divider is bit-a-cycle, so the
// whole item runs on the one shared set of units. The input side is not ready
// while an item is in work; the result sits in an output register so the next
// word is taken while it waits.
// A config write loads the pose register it names.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_pose_update_top
  import ddpu_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // time_step, left_speed, right_speed, aim_x, aim_y
  input  wire logic [79:0]  in_tdata,
  // mode
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, heading_out, dir_x, dir_y
  output logic [111:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int ZW = ANGLE_BITS + 2;
  localparam int SH = 32 - ANGLE_BITS;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt;
  logic [1:0] q_r, q_nxt;
  logic signed [33:0] c_r, c_nxt, s_r, s_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic signed [15:0] vl_r, vl_nxt, vr_r, vr_nxt;
  logic [32:0] dq_r, dq_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [17:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic signed [31:0] r_r, r_nxt;
  logic signed [33:0] relx_r, relx_nxt, rely_r, rely_nxt;
  logic signed [69:0] acc_r, acc_nxt, prod_r;
  logic signed [31:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic [15:0] heading_r, heading_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [111:0] out_data_r, out_data_nxt;

  logic signed [34:0] mul_a, mul_b;
  logic [31:0] rot_ang;
  logic [4:0] idx;
  logic signed [33:0] dx, dy, cx_s, cy_s, cq, sq;
  logic signed [ZW-1:0] atv, cz_s;
  logic ccw;
  logic [31:0] zt, hsum;
  logic [18:0] rs;
  logic signed [16:0] sum17, diff17;
  logic signed [33:0] ax34, ay34;
  logic signed [34:0] qs;
  logic signed [71:0] wide;
  logic signed [69:0] rp;
  logic [31:0] ang_new;
  logic signed [34:0] icx, icy;
  logic last_step;

  // turn angle kept from the multiply that formed it
  logic [31:0] ang_r;
  logic [15:0] ang_turn16;
  logic [32:0] ang_rnd;

  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
    logic [32:0] t;
    t = {1'b0, ATAN_TAB[i]} + (33'd1 << (SH - 1));
    return ZW'(t >> SH);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // shared cordic step
  assign idx  = cnt_r[4:0];
  assign dx   = cy_r >>> idx;
  assign dy   = cx_r >>> idx;
  assign atv  = atan_step(idx);
  assign ccw  = (state_r == S_ROT) ? !cz_r[ZW-1] : !(cy_r > 34'sd0);
  assign cx_s = ccw ? cx_r - dx : cx_r + dx;
  assign cy_s = ccw ? cy_r + dy : cy_r - dy;
  assign cz_s = ccw ? cz_r - atv : cz_r + atv;
  assign last_step = (cnt_r == 6'(CORDIC_STEPS - 1));

  always_comb begin
    unique case (q_r)
      2'd0: begin cq = cx_s;  sq = cy_s;  end
      2'd1: begin cq = -cy_s; sq = cx_s;  end
      2'd2: begin cq = -cx_s; sq = -cy_s; end
      default: begin cq = cy_s; sq = -cx_s; end
    endcase
  end

  assign zt   = {{(32-ZW){cz_s[ZW-1]}}, cz_s} << SH;
  assign hsum = zt + 32'h8000;

  // restoring divide step
  assign rs = {rem_r[17:0], dq_r[32]};

  assign sum17  = 17'(vl_r) + 17'(vr_r);
  assign diff17 = 17'(vr_r) - 17'(vl_r);
  assign ax34   = 34'(signed'(in_tdata[63:48])) <<< 14;
  assign ay34   = 34'(signed'(in_tdata[79:64])) <<< 14;
  assign qs     = neg_r ? -35'(signed'({2'b00, dq_r})) : 35'(signed'({2'b00, dq_r}));
  assign rp     = (prod_r + (70'sd1 <<< 29)) >>> 30;
  assign ang_new = (prod_r[47:16] + 32'(prod_r[15]));
  assign icx    = 35'(pose_x_r) - 35'(relx_r);
  assign icy    = 35'(pose_y_r) - 35'(rely_r);
  assign rot_ang = (state_r == S_M5) ? ang_new : {heading_r, 16'h0000};

  assign ang_rnd    = 33'(ang_r) + 33'h8000;
  assign ang_turn16 = ang_rnd[31:16];

  always_comb begin
    unique case (state_r)
      S_ST1:   begin mul_a = prod_r[34:0];        mul_b = 35'(c_r); end
      S_ST2:   begin mul_a = 35'(r_r);            mul_b = 35'(s_r); end
      S_M1:    begin mul_a = 35'(r_r);            mul_b = 35'(s_r); end
      S_M2:    begin mul_a = 35'(r_r);            mul_b = 35'(c_r); end
      S_M3:    begin mul_a = 35'(diff17) <<< 1;   mul_b = 35'(signed'({1'b0, dt_r})); end
      S_M4:    begin mul_a = prod_r[34:0];        mul_b = RAD_TO_TURN32; end
      S_C1:    begin mul_a = 35'(relx_r);         mul_b = 35'(c_r); end
      S_C2:    begin mul_a = 35'(rely_r);         mul_b = 35'(s_r); end
      S_C3:    begin mul_a = 35'(relx_r);         mul_b = 35'(s_r); end
      S_C4:    begin mul_a = 35'(rely_r);         mul_b = 35'(c_r); end
      default: begin mul_a = 35'(vl_r);           mul_b = 35'(signed'({1'b0, dt_r})); end
    endcase
  end

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; cnt_nxt = cnt_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; q_nxt = q_r;
    c_nxt = c_r; s_nxt = s_r; dt_nxt = dt_r; vl_nxt = vl_r; vr_nxt = vr_r;
    dq_nxt = dq_r; rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r;
    r_nxt = r_r; relx_nxt = relx_r; rely_nxt = rely_r; acc_nxt = acc_r;
    pose_x_nxt = pose_x_r; pose_y_nxt = pose_y_r; heading_nxt = heading_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wide = '0;

    // starting a rotation run, taken up only by states that move to S_ROT
    if (state_r == S_IDLE || state_r == S_FIN || state_r == S_M5) begin
      cx_nxt = KGAIN_Q30; cy_nxt = '0; cnt_nxt = '0;
      cz_nxt = ZW'({2'b00, rot_ang[29:SH]});
      q_nxt  = rot_ang[31:30];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dt_nxt = in_tdata[15:0];
          vl_nxt = in_tdata[31:16];
          vr_nxt = in_tdata[47:32];
          if (!in_tuser) begin
            phase_nxt = P_FIRST;
            state_nxt = S_ROT;
          end else if (ax34 == 34'sd0 && ay34 == 34'sd0) begin
            heading_nxt = '0;
            state_nxt = S_FIN;
          end else begin
            cnt_nxt = '0;
            if (ax34 < 34'sd0) begin
              cx_nxt = -ax34; cy_nxt = -ay34; cz_nxt = ZW'(1) << (ANGLE_BITS - 1);
            end else begin
              cx_nxt = ax34; cy_nxt = ay34; cz_nxt = '0;
            end
            state_nxt = S_VEC;
          end
        end
      end
      S_ROT: begin
        cx_nxt = cx_s; cy_nxt = cy_s; cz_nxt = cz_s; cnt_nxt = cnt_r + 6'd1;
        if (last_step) begin
          c_nxt = cq; s_nxt = sq;
          unique case (phase_r)
            P_FIRST: begin
              if (vl_r == vr_r) begin
                state_nxt = S_ST0;
              end else begin
                dq_nxt  = (sum17[16] ? 33'(-sum17) : 33'(sum17)) << 16;
                den_nxt = diff17[16] ? 18'(-diff17) << 1 : 18'(diff17) << 1;
                neg_nxt = sum17[16] ^ diff17[16];
                rem_nxt = '0;
                cnt_nxt = '0;
                state_nxt = S_DIV;
              end
            end
            P_TURN:  state_nxt = S_C1;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_VEC: begin
        cx_nxt = cx_s; cy_nxt = cy_s; cz_nxt = cz_s; cnt_nxt = cnt_r + 6'd1;
        if (last_step) begin
          heading_nxt = hsum[31:16];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        phase_nxt = P_FINAL;
        state_nxt = S_ROT;
      end
      S_ST0: state_nxt = S_ST1;
      S_ST1: begin
        r_nxt = prod_r[31:0];
        state_nxt = S_ST2;
      end
      S_ST2: begin
        wide = 72'(pose_x_r) + 72'((prod_r + (70'sd1 <<< 37)) >>> 38);
        pose_x_nxt = sat32(wide);
        state_nxt = S_ST3;
      end
      S_ST3: begin
        wide = 72'(pose_y_r) + 72'((prod_r + (70'sd1 <<< 37)) >>> 38);
        pose_y_nxt = sat32(wide);
        state_nxt = S_FIN;
      end
      S_DIV: begin
        if (rs >= {1'b0, den_r}) begin
          rem_nxt = rs - {1'b0, den_r};
          dq_nxt  = {dq_r[31:0], 1'b1};
        end else begin
          rem_nxt = rs;
          dq_nxt  = {dq_r[31:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_BITS - 1)) state_nxt = S_R;
      end
      S_R: begin
        r_nxt = sat32(72'(qs));
        state_nxt = S_M1;
      end
      S_M1: state_nxt = S_M2;
      S_M2: begin
        relx_nxt = rp[33:0];
        state_nxt = S_M3;
      end
      S_M3: begin
        rely_nxt = -rp[33:0];
        state_nxt = S_M4;
      end
      S_M4: state_nxt = S_M5;
      S_M5: begin
        phase_nxt = P_TURN;
        state_nxt = S_ROT;
      end
      S_C1: state_nxt = S_C2;
      S_C2: begin
        acc_nxt = prod_r;
        state_nxt = S_C3;
      end
      S_C3: begin
        wide = ((72'(acc_r) - 72'(prod_r) + (72'sd1 <<< 29)) >>> 30) + 72'(icx);
        pose_x_nxt = sat32(wide);
        state_nxt = S_C4;
      end
      S_C4: begin
        acc_nxt = prod_r;
        state_nxt = S_C5;
      end
      S_C5: begin
        wide = ((72'(acc_r) + 72'(prod_r) + (72'sd1 <<< 29)) >>> 30) + 72'(icy);
        pose_y_nxt = sat32(wide);
        // heading follows the turn rounded to 16 bits
        heading_nxt = heading_r + ang_turn16;
        state_nxt = S_FIN;
      end
      S_OUT: begin
        if (!out_valid_nxt) begin
          out_data_nxt = {to_q14(s_r), to_q14(c_r), heading_r, pose_y_r, pose_x_r};
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_X:   pose_x_nxt = cfg_data;
        REG_START_Y:   pose_y_nxt = cfg_data;
        REG_START_HDG: heading_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_M5) ang_r <= ang_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_FIRST;
      out_valid_r <= 1'b0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      pose_x_r    <= pose_x_nxt;
      pose_y_r    <= pose_y_nxt;
      heading_r   <= heading_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; q_r <= q_nxt;
    c_r <= c_nxt; s_r <= s_nxt; dt_r <= dt_nxt; vl_r <= vl_nxt; vr_r <= vr_nxt;
    dq_r <= dq_nxt; rem_r <= rem_nxt; den_r <= den_nxt; neg_r <= neg_nxt;
    r_r <= r_nxt; relx_r <= relx_nxt; rely_r <= rely_nxt; acc_r <= acc_nxt;
    prod_r <= mul_a * mul_b;
    out_data_r <= out_data_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while busy");

  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROT |-> cnt_r < 6'(CORDIC_STEPS))
    else $error("cordic count overrun");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < 6'(DIV_BITS))
    else $error("divider count overrun");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result lost");

endmodule
`default_nettype wire
